/* src/ses_pkg.sv */
// ses_pkg: shared types, constants and the gray weight tables of the sobel edge stream
// no dependencies; compiled first

package ses_pkg;

   // pixel and result field widths
   localparam int COLOR_W    = 8;
   localparam int GRAY_W     = 8;
   localparam int ROW_W      = 16;
   localparam int COL_OUT_W  = 10;
   localparam int REG_WIDTH_W  = 11;
   localparam int REG_HEIGHT_W = 16;

   // configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register reset values and frame limits
   localparam logic [REG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [REG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
   localparam int MIN_DIM = 3;

   // window geometry and output clamp
   localparam int WIN_COLS = 3;
   localparam logic [GRAY_W-1:0] EDGE_MAX = 8'hFF;

   // luma weights in units of 1/10000
   localparam int unsigned WEIGHT_SCALE = 10000;
   localparam int unsigned WEIGHT_B = 722;
   localparam int unsigned WEIGHT_G = 7152;
   localparam int unsigned WEIGHT_R = 2126;

   // register codes, selected by the word address bit
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } csr_reg_type;

   // one column of the 3x3 window
   typedef struct packed {
      logic [GRAY_W-1:0] top;
      logic [GRAY_W-1:0] mid;
      logic [GRAY_W-1:0] bot;
   } column_type;

   // one line store entry: two rows back and one row back
   typedef struct packed {
      logic [GRAY_W-1:0] older;
      logic [GRAY_W-1:0] newer;
   } line_pair_type;

   // result bookkeeping that travels with a pixel down the pipe
   typedef struct packed {
      logic                 emit;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] column;
      logic                 last;
   } stage_meta_type;

   // truncated weighted channel value for every 8-bit code, built at elaboration
   function automatic logic [255:0][GRAY_W-1:0] weight_table(input int unsigned weight);
      logic [255:0][GRAY_W-1:0] t;
      for (int i = 0; i < 256; i++) begin
         t[i] = GRAY_W'((i * weight) / WEIGHT_SCALE);
      end
      return t;
   endfunction

   localparam logic [255:0][GRAY_W-1:0] GRAY_B_TABLE = weight_table(WEIGHT_B);
   localparam logic [255:0][GRAY_W-1:0] GRAY_G_TABLE = weight_table(WEIGHT_G);
   localparam logic [255:0][GRAY_W-1:0] GRAY_R_TABLE = weight_table(WEIGHT_R);

endpackage

/* src/ses_if.sv */
// ses_req_if and ses_rsp_if: valid/ready channels for pixel beats and result beats
// depends on ses_pkg for field widths

interface ses_req_if import ses_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] blue;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] red;
   logic               frame_start;

   modport source (output valid, blue, green, red, frame_start, input ready);
   modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface ses_rsp_if import ses_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [GRAY_W-1:0]    edge_res;
   logic [ROW_W-1:0]     row;
   logic [COL_OUT_W-1:0] column;
   logic                 last_of_frame;

   modport source (output valid, edge_res, row, column, last_of_frame, input ready);
   modport sink   (input valid, edge_res, row, column, last_of_frame, output ready);
endinterface

/* src/ses_cell.sv */
// ses_cell: one window column cell, takes its neighbor's column on every shift
// depends on ses_pkg for column_type

module ses_cell import ses_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  column_type col_in,
   output column_type col_out
);

   column_type col_ff;

   // column register, cleared to zero gray at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

/* src/ses_line_store.sv */
// ses_line_store: both row stores as one dual-byte memory, registered read with write bypass
// depends on ses_pkg for line_pair_type

module ses_line_store import ses_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output line_pair_type            rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  line_pair_type            wr_data
);

   line_pair_type mem_ff [DEPTH];
   line_pair_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, a same-edge write to the same entry is passed through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ses_gradient.sv */
// ses_gradient: sobel x and y kernels over the three window columns, |gx|+|gy| clamped
// depends on ses_pkg for column_type and EDGE_MAX

module ses_gradient import ses_pkg::*; (
   input  column_type        left_col,
   input  column_type        center_col,
   input  column_type        right_col,
   output logic [GRAY_W-1:0] edge_mag
);

   logic signed [11:0] lt, lm, lb, ct, cb, rt, rm, rb;
   logic signed [11:0] gx, gy;
   logic        [10:0] abs_x, abs_y;
   logic        [11:0] sum;

   // widen taps to signed
   assign lt = signed'(12'(left_col.top));
   assign lm = signed'(12'(left_col.mid));
   assign lb = signed'(12'(left_col.bot));
   assign ct = signed'(12'(center_col.top));
   assign cb = signed'(12'(center_col.bot));
   assign rt = signed'(12'(right_col.top));
   assign rm = signed'(12'(right_col.mid));
   assign rb = signed'(12'(right_col.bot));

   // left minus right, top minus bottom, center taps weighted two
   assign gx = lt + (lm <<< 1) + lb - rt - (rm <<< 1) - rb;
   assign gy = lt + (ct <<< 1) + rt - lb - (cb <<< 1) - rb;

   // magnitudes and clamp
   assign abs_x = 11'(gx[11] ? -gx : gx);
   assign abs_y = 11'(gy[11] ? -gy : gy);
   assign sum   = 12'(abs_x) + 12'(abs_y);
   assign edge_mag = (sum > 12'(EDGE_MAX)) ? EDGE_MAX : sum[GRAY_W-1:0];

endmodule

/* src/sobel_edge_stream_unit.sv */
// sobel_edge_stream_unit: top level of the 3x3 sobel edge detector over a raster pixel stream
// depends on ses_pkg, ses_if, ses_cell, ses_line_store and ses_gradient
//
// Usage:
//   req carries one RGB pixel per beat in raster order; frame_start marks the first
//   pixel of a frame and clears the row and column counters. Frames may also follow
//   each other without it, the counters wrap after the last pixel.
//   rsp carries one beat per interior pixel: the clamped gradient magnitude, the
//   pixel's row and column, and last_of_frame on the final interior pixel. Pixels on
//   the first and last rows and columns give no beat.
//   csr sets image_width (byte address 0) and image_height (address 4); write them
//   only while no pixel is in flight.
// Timing:
//   one pixel per clock sustained while rsp does not stall. The pipe is gray lookup,
//   line store read, window shift and gradient into the output register; the line
//   store takes one read and one write per pixel on separate ports and the window
//   shifts once per pixel, which sets the rate. When rsp stalls with an emitting
//   item in stage 2, the pipe holds and req.ready falls once stage 1 is occupied;
//   those items behind the output register stay put. Reset empties the pipe, zeroes
//   window and counters and loads 640x480; the line stores are not cleared.

module sobel_edge_stream_unit import ses_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   ses_req_if.sink               req,
   ses_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > REG_WIDTH_W) ? WW : REG_WIDTH_W;

   // configuration registers
   logic [REG_WIDTH_W-1:0]  width_ff;
   logic [REG_HEIGHT_W-1:0] height_ff;
   logic                    csr_write;
   csr_reg_type             csr_sel;

   // position counters
   logic [CW-1:0]    col_count_ff;
   logic [ROW_W-1:0] row_count_ff;

   // pipe stage after accept: gray value, store address, result bookkeeping
   logic              s1_valid_ff;
   logic [GRAY_W-1:0] s1_gray_ff;
   logic [CW-1:0]     s1_addr_ff;
   stage_meta_type    s1_meta_ff;

   // pipe stage that owns the current window
   logic           s2_valid_ff;
   stage_meta_type s2_meta_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [GRAY_W-1:0]    rsp_edge_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic                 rsp_last_ff;

   // handshake and flow signals
   logic accept, out_free, s2_adv, s2_free, s1_adv, s1_free;

   // position and frame geometry of the incoming pixel
   logic [CW-1:0]     c_cur;
   logic [ROW_W-1:0]  r_cur;
   logic [CMPW-1:0]   w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic              row_end, frame_end;
   logic [CW-1:0]     c_m1;
   logic [9:0]        gray_sum;
   logic [GRAY_W-1:0] gray;
   stage_meta_type    meta_in;

   // window and store signals
   line_pair_type rd_pair;
   line_pair_type wr_pair;
   column_type    new_col;
   column_type    win_col [WIN_COLS];
   logic [GRAY_W-1:0] edge_mag;

   // ---------------- configuration port ----------------

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_WIDTH:  width_ff  <= csr_pwdata[REG_WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[REG_HEIGHT_W-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_sel)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s2_adv   = s2_valid_ff && (!s2_meta_ff.emit || out_free);
   assign s2_free  = !s2_valid_ff || s2_adv;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_adv;
   assign req.ready = s1_free;
   assign accept   = req.valid && req.ready;

   // ---------------- position and gray of the incoming beat ----------------

   assign c_cur = req.frame_start ? '0 : col_count_ff;
   assign r_cur = req.frame_start ? '0 : row_count_ff;

   // effective frame size, both sides at least MIN_DIM, width kept within the line store
   always_comb begin
      priority if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else if (CMPW'(width_ff) < CMPW'(MIN_DIM)) begin
         w_eff = CMPW'(MIN_DIM);
      end else begin
         w_eff = CMPW'(width_ff);
      end
   end
   assign h_eff = (height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_ff;

   assign row_end   = (CMPW'(c_cur) + CMPW'(1)) >= w_eff;
   assign frame_end = row_end && ((17'(r_cur) + 17'd1) >= 17'(h_eff));

   // luma from per-channel truncated tables, largest sum 254
   assign gray_sum = 10'(GRAY_B_TABLE[req.blue]) + 10'(GRAY_G_TABLE[req.green])
                   + 10'(GRAY_R_TABLE[req.red]);
   assign gray     = gray_sum[GRAY_W-1:0];

   // the window centers one row up and one column left of the incoming pixel
   assign c_m1           = c_cur - CW'(1);
   assign meta_in.emit   = (c_cur >= CW'(2)) && (r_cur >= ROW_W'(2));
   assign meta_in.row    = r_cur - ROW_W'(1);
   assign meta_in.column = COL_OUT_W'(c_m1);
   assign meta_in.last   = frame_end;

   // counters step once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_count_ff <= '0;
            row_count_ff <= frame_end ? '0 : r_cur + ROW_W'(1);
         end else begin
            col_count_ff <= c_cur + CW'(1);
            row_count_ff <= r_cur;
         end
      end
   end

   // ---------------- stage 1: store read in flight ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff <= gray;
         s1_addr_ff <= c_cur;
         s1_meta_ff <= meta_in;
      end
   end

   // row stores: older takes what newer held, newer takes this pixel
   assign wr_pair.older = rd_pair.newer;
   assign wr_pair.newer = s1_gray_ff;

   ses_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (rd_pair),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_pair)
   );

   // ---------------- window: chain of column cells ----------------

   assign new_col.top = rd_pair.older;
   assign new_col.mid = rd_pair.newer;
   assign new_col.bot = s1_gray_ff;

   for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
      column_type col_in;
      if (i == WIN_COLS - 1) begin : g_head
         assign col_in = new_col;
      end else begin : g_link
         assign col_in = win_col[i+1];
      end
      ses_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (s1_adv),
         .col_in   (col_in),
         .col_out  (win_col[i])
      );
   end

   // ---------------- stage 2: gradient of the held window ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   ses_gradient u_gradient (
      .left_col   (win_col[0]),
      .center_col (win_col[1]),
      .right_col  (win_col[2]),
      .edge_mag   (edge_mag)
   );

   // ---------------- output register ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff && s2_meta_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff && s2_meta_ff.emit) begin
         rsp_edge_ff <= edge_mag;
         rsp_row_ff  <= s2_meta_ff.row;
         rsp_col_ff  <= s2_meta_ff.column;
         rsp_last_ff <= s2_meta_ff.last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.edge_res      = rsp_edge_ff;
   assign rsp.row           = rsp_row_ff;
   assign rsp.column        = rsp_col_ff;
   assign rsp.last_of_frame = rsp_last_ff;

   // ---------------- assertions ----------------

   // a result beat only appears after an emitting window left stage 2
   a_rsp_from_window: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_meta_ff.emit))
      else $error("result beat without an emitting window");

   // an accepted pixel always occupies stage 1 on the next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel lost before stage 1");

   // the window must not move while stage 2 still holds its item
   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_adv) |=> $stable(win_col[WIN_COLS-1]))
      else $error("window shifted under a held item");

   // the column counter never points past the line store
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CMPW'(col_count_ff) < CMPW'(MAX_WIDTH))
      else $error("column counter out of line store range");

endmodule

/* tb/testbench.sv */
// testbench for sobel_edge_stream_unit: pixel frames in, predicted gradient beats checked out
// depends on ses_pkg, ses_if and the sobel_edge_stream_unit rtl

module testbench import ses_pkg::*; ();

   localparam int PIX_MAX_W = 1024;

   // idling schemes applied per phase
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one result beat as seen on rsp
   typedef struct packed {
      logic [GRAY_W-1:0]    magnitude;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] column;
      logic                 last_of_frame;
   } edge_beat_type;

   // line stores, window and position counters tracked beat by beat
   class gradient_predictor;
      int                      older_line[PIX_MAX_W];
      int                      newer_line[PIX_MAX_W];
      int                      win[3][3];
      int unsigned             col_pos;
      int unsigned             row_pos;
      logic [REG_WIDTH_W-1:0]  width_reg = WIDTH_RESET;
      logic [REG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
      edge_beat_type           expected_edges[$];
      int                      failures;

      function void report(string msg);
         failures++;
         if (failures <= 10) $display("mismatch: %s", msg);
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction

      // shift one gray pixel in and queue the gradient it completes, if any
      function void accept_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
         int unsigned   w, h, c, rw, gray;
         int            gx, gy, mag;
         logic          row_end, frame_end;
         edge_beat_type beat;
         w = 32'(width_reg);
         h = 32'(height_reg);
         if (w < MIN_DIM) w = MIN_DIM;
         if (w > PIX_MAX_W) w = PIX_MAX_W;
         if (h < MIN_DIM) h = MIN_DIM;
         if (fs) begin
            col_pos = 0;
            row_pos = 0;
         end
         c = col_pos;
         rw = row_pos;
         if (c >= PIX_MAX_W) c = PIX_MAX_W - 1;
         // per-channel truncated luma
         gray = (b * WEIGHT_B) / WEIGHT_SCALE + (g * WEIGHT_G) / WEIGHT_SCALE
              + (r * WEIGHT_R) / WEIGHT_SCALE;
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = older_line[c];
         win[1][2] = newer_line[c];
         win[2][2] = gray;
         older_line[c] = newer_line[c];
         newer_line[c] = gray;
         row_end = (c + 1 >= w);
         frame_end = row_end && (rw + 1 >= h);
         // interior pixel sits one row up and one column left
         if (c >= 2 && rw >= 2) begin
            gx = win[0][0] - win[0][2] + 2 * win[1][0] - 2 * win[1][2]
               + win[2][0] - win[2][2];
            gy = win[0][0] + 2 * win[0][1] + win[0][2]
               - win[2][0] - 2 * win[2][1] - win[2][2];
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > int'(EDGE_MAX)) mag = int'(EDGE_MAX);
            beat.magnitude = GRAY_W'(mag);
            beat.row = ROW_W'(rw - 1);
            beat.column = COL_OUT_W'(c - 1);
            beat.last_of_frame = frame_end;
            expected_edges.push_back(beat);
         end
         if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : ((rw + 1) & 32'hFFFF);
         end else begin
            col_pos = c + 1;
         end
      endfunction

      // compare one accepted result beat with the oldest expectation
      function void check_result(edge_beat_type got);
         edge_beat_type want;
         if (expected_edges.size() == 0) begin
            report($sformatf("unexpected beat edge=%0d row=%0d col=%0d last=%0b",
                             got.magnitude, got.row, got.column, got.last_of_frame));
            return;
         end
         want = expected_edges.pop_front();
         if (got.magnitude !== want.magnitude || got.row !== want.row ||
             got.column !== want.column || got.last_of_frame !== want.last_of_frame)
            report($sformatf("edge/row/col/last expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             want.magnitude, want.row, want.column, want.last_of_frame,
                             got.magnitude, got.row, got.column, got.last_of_frame));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    gap_pct;
   int                    stall_pct;
   int                    pixels_sent;
   gradient_predictor     tracker;

   ses_req_if req_bus();
   ses_rsp_if rsp_bus();

   sobel_edge_stream_unit #(.MAX_WIDTH(PIX_MAX_W)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result beats are sampled mid-cycle, accepted at the following edge
   always @(negedge clock) begin
      edge_beat_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.magnitude = rsp_bus.edge_res;
         got.row = rsp_bus.row;
         got.column = rsp_bus.column;
         got.last_of_frame = rsp_bus.last_of_frame;
         tracker.check_result(got);
      end
   end

   function automatic void set_idle_mode(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            gap_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 71;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;
            stall_pct = 71;
         end
         default: begin
            gap_pct = 21;
            stall_pct = 21;
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // apb write: setup then access, register loads at the access edge
   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read_check(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want)
         tracker.report($sformatf("register %s read expected %0d got %0d",
                                  idx.name(), want, got));
   endtask

   // both registers, with junk above the field, then read back
   task automatic set_frame_size(input int unsigned w, input int unsigned h);
      csr_write(REG_WIDTH, ($urandom() & ~((32'd1 << REG_WIDTH_W) - 1)) | w);
      csr_write(REG_HEIGHT, ($urandom() & ~((32'd1 << REG_HEIGHT_W) - 1)) | h);
      tracker.width_reg = REG_WIDTH_W'(w);
      tracker.height_reg = REG_HEIGHT_W'(h);
      csr_read_check(REG_WIDTH, w);
      csr_read_check(REG_HEIGHT, h);
   endtask

   // one pixel beat; valid stays high afterwards unless the next call idles
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input logic fs);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.blue <= b;
      req_bus.green <= g;
      req_bus.red <= r;
      req_bus.frame_start <= fs;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      tracker.accept_pixel(b, g, r, fs);
      pixels_sent++;
   endtask

   // raster frame with random content, sometimes cut short or restarted midway
   task automatic send_frame(input int unsigned w, input int unsigned h, input logic mark);
      int unsigned total;
      int unsigned cut;
      total = w * h;
      cut = total;
      if ($urandom_range(99) < 12) cut = $urandom_range(1, total - 1);
      for (int unsigned n = 0; n < cut; n++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(),
                    (n == 0) ? mark : ($urandom_range(199) == 0));
   endtask

   // hold the sender until every expected beat is back and the pipe is empty
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned w_cfg, h_cfg, w_eff, h_eff;
      int          phase;
      tracker = new();
      set_idle_mode(IDLE_NONE);
      req_bus.valid <= 1'b0;
      req_bus.blue <= '0;
      req_bus.green <= '0;
      req_bus.red <= '0;
      req_bus.frame_start <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values, then sizes below the minimum
      csr_read_check(REG_WIDTH, CSR_DATA_W'(WIDTH_RESET));
      csr_read_check(REG_HEIGHT, CSR_DATA_W'(HEIGHT_RESET));
      set_frame_size(0, 0);

      // white left column over black: gradient clamps
      for (int k = 0; k < 3; k++) begin
         send_pixel(8'hFF, 8'hFF, 8'hFF, k == 0);
         send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
         send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      end
      // broken frame, then restart with single-channel pixels
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      for (int k = 0; k < 9; k++)
         send_pixel((k % 3 == 0) ? 8'hFF : 8'h00, (k % 3 == 1) ? 8'hFF : 8'h00,
                    (k % 3 == 2) ? 8'hFF : 8'h00, k == 0);
      // flat frame entered by wrap alone: zero gradient
      for (int k = 0; k < 9; k++)
         send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
      wait_idle();

      // widest row: the column counter runs to the top of the line store
      set_frame_size(PIX_MAX_W, 3);
      for (int k = 0; k < PIX_MAX_W; k++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), k == 0);
      wait_idle();

      // width above the limit, then shrunk under the running column
      set_idle_mode(IDLE_BOTH);
      set_frame_size((1 << REG_WIDTH_W) - 1, 4);
      for (int k = 0; k < 20; k++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), k == 0);
      wait_idle();
      set_frame_size(8, 4);
      send_frame(1, 1, 1'b0);
      send_frame(8, 3, 1'b0);
      wait_idle();

      // tallest frame, then height shrunk under the running row
      set_frame_size(4, (1 << REG_HEIGHT_W) - 1);
      for (int k = 0; k < 24; k++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), k == 0);
      wait_idle();
      set_frame_size(4, 3);
      for (int k = 0; k < 4; k++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0);
      wait_idle();

      // random phases: new sizes and idling scheme each time
      phase = 0;
      while (pixels_sent < 1650) begin
         set_idle_mode(idle_mode_type'(phase % 4));
         case ($urandom_range(9))
            0: w_cfg = $urandom_range(0, 2);
            1: w_cfg = $urandom_range(17, 40);
            default: w_cfg = $urandom_range(3, 12);
         endcase
         h_cfg = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         set_frame_size(w_cfg, h_cfg);
         w_eff = (w_cfg < MIN_DIM) ? MIN_DIM : w_cfg;
         h_eff = (h_cfg < MIN_DIM) ? MIN_DIM : h_cfg;
         for (int f = $urandom_range(1, 3); f > 0; f--)
            send_frame(w_eff, h_eff, (f == 1) ? 1'b1 : 1'($urandom_range(1)));
         wait_idle();
         phase++;
      end

      if (tracker.failures == 0)
         $display("sobel_edge_stream_unit verification clean");
      else
         $display("sobel_edge_stream_unit verification failed");
      $finish;
   end

   // hang guard
   initial begin
      #8000000;
      $display("sobel_edge_stream_unit verification failed");
      $finish;
   end

endmodule
